>>> hdl/h264fi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264fi_pkg
// Types and constants shared by the H.264 frame indexer.
// ----------------------------------------------------------------------------
package h264fi_pkg;

   localparam int unsigned CountWidth  = 20;
   localparam int unsigned WordWidth   = 32;
   localparam int unsigned AddrWidth   = 4;

   localparam logic [7:0] NalTypeMask = 8'h1f;
   localparam logic [7:0] StartMark   = 8'h01;
   localparam logic [4:0] NalTypeSps  = 5'd7;
   localparam logic [4:0] NalTypePps  = 5'd8;

   localparam logic [CountWidth-1:0] FrameLimitReset = 20'd1024;
   localparam logic [CountWidth-1:0] SyncLimitReset  = 20'd32;

   typedef enum logic [1:0] {
      REG_BASE_OFFSET = 2'd0,
      REG_FRAME_LIMIT = 2'd1,
      REG_SYNC_LIMIT  = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_HDR1  = 3'd0,
      PH_SCAN1 = 3'd1,
      PH_HDR2  = 3'd2,
      PH_SCAN2 = 3'd3,
      PH_HDR3  = 3'd4,
      PH_KEY   = 3'd5,
      PH_FAIL  = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] zero_run;
      logic       awaiting_type;
      logic       previous_was_zero;
   } parse_type;

endpackage

>>> hdl/h264_frame_indexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_frame_indexer_unit
// Annex B key frame detector and sample table indexer.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while req_stall is low; the parser and the
// counters update on each accepted byte, and a frame's record appears in the
// output register in the cycle after its last byte is accepted. Bytes that do
// not end a frame are accepted even while a record waits to be taken; a last
// byte waits only while the output register is full and stalled. The user must
// write configuration over the CSR port only while no frame is in flight; the
// block does not enforce it. A base offset write also restarts the running offset.
module h264_frame_indexer_unit
   import h264fi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_is_key,
   output logic                   rsp_sync_recorded,
   output logic [CountWidth-1:0]  rsp_sample_number,
   output logic                   rsp_size_recorded,
   output logic [WordWidth-1:0]   rsp_frame_size,
   output logic [WordWidth-1:0]   rsp_frame_offset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [AddrWidth-1:0]   csr_paddr,
   input  logic [WordWidth-1:0]   csr_pwdata,
   output logic [WordWidth-1:0]   csr_prdata,
   output logic                   csr_pready
);

   logic [WordWidth-1:0]  base_offset_ff;
   logic [CountWidth-1:0] frame_limit_ff;
   logic [CountWidth-1:0] sync_limit_ff;

   parse_type             parse_ff, parse_in, parse_step;
   logic [WordWidth-1:0]  byte_count_ff, byte_count_in, byte_count_inc;
   logic [WordWidth-1:0]  running_offset_ff, running_offset_in;
   logic [CountWidth-1:0] size_entries_ff, size_entries_in;
   logic [CountWidth-1:0] sync_entries_ff, sync_entries_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_is_key_ff, rsp_sync_recorded_ff, rsp_size_recorded_ff;
   logic [CountWidth-1:0] rsp_sample_number_ff;
   logic [WordWidth-1:0]  rsp_frame_size_ff, rsp_frame_offset_ff;

   logic                  req_accept, frame_done, rsp_take;
   logic                  cfg_write, key_hit, sync_ok, size_ok;
   reg_index_type         cfg_index;
   logic [4:0]            nal_type;

   assign csr_pready = 1'b1;
   assign cfg_index  = reg_index_type'(csr_paddr[AddrWidth-1:2]);
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (cfg_index)
         REG_BASE_OFFSET: csr_prdata = base_offset_ff;
         REG_FRAME_LIMIT: csr_prdata = {{(WordWidth-CountWidth){1'b0}}, frame_limit_ff};
         REG_SYNC_LIMIT:  csr_prdata = {{(WordWidth-CountWidth){1'b0}}, sync_limit_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_offset_ff <= '0;
         frame_limit_ff <= FrameLimitReset;
         sync_limit_ff  <= SyncLimitReset;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_BASE_OFFSET: base_offset_ff <= csr_pwdata;
            REG_FRAME_LIMIT: frame_limit_ff <= csr_pwdata[CountWidth-1:0];
            REG_SYNC_LIMIT:  sync_limit_ff  <= csr_pwdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = req_frame_end && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign frame_done = req_accept && req_frame_end;

   // byte-wise start code parser
   assign nal_type = req_data_byte[4:0] & NalTypeMask[4:0];

   always_comb begin
      parse_step = parse_ff;
      unique case (parse_ff.phase)
         PH_HDR1, PH_HDR2, PH_HDR3: begin
            priority if (parse_ff.awaiting_type) begin
               parse_step.awaiting_type     = 1'b0;
               parse_step.previous_was_zero = 1'b0;
               priority if (parse_ff.phase == PH_HDR1) begin
                  parse_step.phase = (nal_type == NalTypeSps) ? PH_SCAN1 : PH_FAIL;
               end else if (parse_ff.phase == PH_HDR2) begin
                  parse_step.phase = (nal_type == NalTypePps) ? PH_SCAN2 : PH_FAIL;
               end else begin
                  parse_step.phase = PH_KEY;
               end
            end else if (req_data_byte == 8'h00) begin
               parse_step.zero_run = parse_ff.zero_run + 3'd1;
               if (parse_ff.zero_run >= 3'd3) begin
                  parse_step.phase = PH_FAIL;
               end
            end else if (req_data_byte == StartMark && parse_ff.zero_run >= 3'd2) begin
               parse_step.awaiting_type = 1'b1;
            end else begin
               parse_step.phase = PH_FAIL;
            end
         end
         PH_SCAN1, PH_SCAN2: begin
            if (parse_ff.previous_was_zero && req_data_byte == 8'h00) begin
               parse_step.phase = (parse_ff.phase == PH_SCAN1) ? PH_HDR2 : PH_HDR3;
               parse_step.zero_run          = 3'd1;
               parse_step.previous_was_zero = 1'b0;
            end else begin
               parse_step.previous_was_zero = (req_data_byte == 8'h00);
            end
         end
         default: ;
      endcase
   end

   assign byte_count_inc = byte_count_ff + 32'd1;
   assign key_hit        = (parse_step.phase == PH_KEY);
   assign sync_ok        = key_hit && (sync_entries_ff < sync_limit_ff);
   assign size_ok        = (size_entries_ff < frame_limit_ff);

   always_comb begin
      parse_in          = parse_ff;
      byte_count_in     = byte_count_ff;
      running_offset_in = running_offset_ff;
      size_entries_in   = size_entries_ff;
      sync_entries_in   = sync_entries_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_take;
      if (frame_done) begin
         parse_in          = '{phase: PH_HDR1, zero_run: 3'd0,
                               awaiting_type: 1'b0, previous_was_zero: 1'b0};
         byte_count_in     = '0;
         running_offset_in = running_offset_ff + byte_count_inc;
         if (size_ok) begin
            size_entries_in = size_entries_ff + 20'd1;
         end
         if (sync_ok) begin
            sync_entries_in = sync_entries_ff + 20'd1;
         end
         rsp_valid_in = 1'b1;
      end else if (req_accept) begin
         parse_in      = parse_step;
         byte_count_in = byte_count_inc;
      end
      if (cfg_write && cfg_index == REG_BASE_OFFSET) begin
         running_offset_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff          <= '{phase: PH_HDR1, zero_run: 3'd0,
                                awaiting_type: 1'b0, previous_was_zero: 1'b0};
         byte_count_ff     <= '0;
         running_offset_ff <= '0;
         size_entries_ff   <= '0;
         sync_entries_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         parse_ff          <= parse_in;
         byte_count_ff     <= byte_count_in;
         running_offset_ff <= running_offset_in;
         size_entries_ff   <= size_entries_in;
         sync_entries_ff   <= sync_entries_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         rsp_is_key_ff        <= key_hit;
         rsp_sync_recorded_ff <= sync_ok;
         rsp_sample_number_ff <= size_entries_ff;
         rsp_size_recorded_ff <= size_ok;
         rsp_frame_size_ff    <= byte_count_inc;
         rsp_frame_offset_ff  <= running_offset_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_key        = rsp_is_key_ff;
   assign rsp_sync_recorded = rsp_sync_recorded_ff;
   assign rsp_sample_number = rsp_sample_number_ff;
   assign rsp_size_recorded = rsp_size_recorded_ff;
   assign rsp_frame_size    = rsp_frame_size_ff;
   assign rsp_frame_offset  = rsp_frame_offset_ff;

`ifndef SYNTHESIS
   a_done_gives_record: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> rsp_valid_ff)
      else $error("frame end transaction did not produce a record");

   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !frame_done) |=> !rsp_valid_ff)
      else $error("record repeated after it was taken");

   a_count_restarts: assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (byte_count_ff == '0 && parse_ff.phase == PH_HDR1))
      else $error("parser not cleared after frame end");

   a_sync_needs_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_sync_recorded_ff || rsp_is_key_ff))
      else $error("sync entry recorded for a non-key frame");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the H.264 Annex B frame indexer.
// A queue of frame bytes feeds a clocked driver. A predictor tracks the
// start code parser, the table counters and the running offset, and it runs
// on every accepted byte. A clocked monitor compares each record with the
// oldest predicted one. The run steps through several register settings and
// idle/stall mixes, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench
   import h264fi_pkg::*;
();

   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   typedef struct {
      logic                  is_key;
      logic                  sync_recorded;
      logic [CountWidth-1:0] sample_number;
      logic                  size_recorded;
      logic [WordWidth-1:0]  frame_size;
      logic [WordWidth-1:0]  frame_offset;
   } index_record_type;

   typedef logic [7:0] byte_queue_type[$];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_is_key;
   logic                  rsp_sync_recorded;
   logic [CountWidth-1:0] rsp_sample_number;
   logic                  rsp_size_recorded;
   logic [WordWidth-1:0]  rsp_frame_size;
   logic [WordWidth-1:0]  rsp_frame_offset;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [AddrWidth-1:0]  csr_paddr = '0;
   logic [WordWidth-1:0]  csr_pwdata = '0;
   logic [WordWidth-1:0]  csr_prdata;
   logic                  csr_pready;

   frame_byte_type   byte_backlog[$];
   index_record_type records_due[$];
   int               sender_idle_pct = 0;
   int               recv_stall_pct = 0;
   logic             hold_on = 1'b0;
   int               errors = 0;

   // predictor copy of registers and state
   logic [WordWidth-1:0]  cfg_base = '0;
   logic [CountWidth-1:0] cfg_frame_limit = FrameLimitReset;
   logic [CountWidth-1:0] cfg_sync_limit = SyncLimitReset;
   phase_type             ix_phase = PH_HDR1;
   logic [2:0]            ix_zero_run = '0;
   logic                  ix_awaiting = 1'b0;
   logic                  ix_prev_zero = 1'b0;
   logic [WordWidth-1:0]  ix_byte_count = '0;
   logic [WordWidth-1:0]  ix_run_offset = '0;
   logic [CountWidth-1:0] ix_size_entries = '0;
   logic [CountWidth-1:0] ix_sync_entries = '0;

   h264_frame_indexer_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_key        (rsp_is_key),
      .rsp_sync_recorded (rsp_sync_recorded),
      .rsp_sample_number (rsp_sample_number),
      .rsp_size_recorded (rsp_size_recorded),
      .rsp_frame_size    (rsp_frame_size),
      .rsp_frame_offset  (rsp_frame_offset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("FAIL h264_frame_indexer_unit");
      $finish;
   end

   task automatic parse_header(input logic [7:0] b);
      if (ix_awaiting) begin
         ix_awaiting = 1'b0;
         ix_prev_zero = 1'b0;
         case (ix_phase)
            PH_HDR1: begin
               ix_phase = ((b & NalTypeMask) == {3'b000, NalTypeSps}) ? PH_SCAN1 : PH_FAIL;
            end
            PH_HDR2: begin
               ix_phase = ((b & NalTypeMask) == {3'b000, NalTypePps}) ? PH_SCAN2 : PH_FAIL;
            end
            default: begin
               ix_phase = PH_KEY;
            end
         endcase
      end else if (b == 8'h00) begin
         ix_zero_run = ix_zero_run + 3'd1;
         if (ix_zero_run >= 3'd4) ix_phase = PH_FAIL;
      end else if (b == StartMark && ix_zero_run >= 3'd2) begin
         ix_awaiting = 1'b1;
      end else begin
         ix_phase = PH_FAIL;
      end
   endtask

   task automatic index_byte(input logic [7:0] b, input logic last);
      index_record_type rec;
      ix_byte_count = ix_byte_count + 32'd1;
      case (ix_phase)
         PH_HDR1, PH_HDR2, PH_HDR3: begin
            parse_header(b);
         end
         PH_SCAN1, PH_SCAN2: begin
            if (ix_prev_zero && b == 8'h00) begin
               ix_phase = phase_type'(ix_phase + 3'd1);
               ix_zero_run = 3'd1;
               ix_prev_zero = 1'b0;
            end else begin
               ix_prev_zero = (b == 8'h00);
            end
         end
         default: ;
      endcase
      if (last) begin
         rec.is_key = (ix_phase == PH_KEY);
         rec.sync_recorded = rec.is_key && (ix_sync_entries < cfg_sync_limit);
         rec.sample_number = ix_size_entries;
         rec.size_recorded = (ix_size_entries < cfg_frame_limit);
         rec.frame_size = ix_byte_count;
         rec.frame_offset = ix_run_offset;
         records_due.push_back(rec);
         if (rec.sync_recorded) ix_sync_entries = ix_sync_entries + 20'd1;
         if (rec.size_recorded) ix_size_entries = ix_size_entries + 20'd1;
         ix_run_offset = ix_run_offset + ix_byte_count;
         ix_phase = PH_HDR1;
         ix_zero_run = '0;
         ix_awaiting = 1'b0;
         ix_prev_zero = 1'b0;
         ix_byte_count = '0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      frame_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) index_byte(req_data_byte, req_frame_end);
         if (req_valid && req_stall) begin
            // hold the stalled transaction
         end else if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            nxt = byte_backlog.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nxt.data;
            req_frame_end <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      index_record_type rec;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (records_due.size() == 0) begin
               $display("%0t: record with no transaction pending, expected none actual %h",
                        $time, rsp_frame_size);
               errors++;
            end else begin
               rec = records_due.pop_front();
               check_field("is_key", 32'(rec.is_key), 32'(rsp_is_key));
               check_field("sync_recorded", 32'(rec.sync_recorded), 32'(rsp_sync_recorded));
               check_field("sample_number", 32'(rec.sample_number), 32'(rsp_sample_number));
               check_field("size_recorded", 32'(rec.size_recorded), 32'(rsp_size_recorded));
               check_field("frame_size", rec.frame_size, rsp_frame_size);
               check_field("frame_offset", rec.frame_offset, rsp_frame_offset);
            end
         end
         rsp_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_BASE_OFFSET: begin
            cfg_base = value;
            ix_run_offset = cfg_base;
         end
         REG_FRAME_LIMIT: cfg_frame_limit = value[CountWidth-1:0];
         REG_SYNC_LIMIT:  cfg_sync_limit = value[CountWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic add_frame(input byte_queue_type bytes);
      frame_byte_type fb;
      for (int i = 0; i < bytes.size(); i++) begin
         fb.data = bytes[i];
         fb.last = (i == bytes.size() - 1);
         byte_backlog.push_back(fb);
      end
   endtask

   task automatic add_random_frame(output int nbytes);
      byte_queue_type q;
      int zeros;
      logic [7:0] nal;
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 12)) begin
            q.push_back(($urandom_range(2) == 0) ? 8'h00 : 8'($urandom));
         end
      end else begin
         for (int n = 0; n < 3; n++) begin
            // after a header the scan eats one zero of the pair
            zeros = (n == 0) ? 2 + $urandom_range(1) : 3 + $urandom_range(1);
            if ($urandom_range(99) < 10) zeros = $urandom_range(0, 5);
            repeat (zeros) q.push_back(8'h00);
            q.push_back(StartMark);
            case (n)
               0: nal = {3'($urandom), NalTypeSps};
               1: nal = {3'($urandom), NalTypePps};
               default: nal = 8'($urandom);
            endcase
            if ($urandom_range(99) < 8) nal = 8'($urandom);
            q.push_back(nal);
            if (n < 2) begin
               repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(1, 255)));
            end
         end
         repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
         if ($urandom_range(99) < 15) begin
            zeros = $urandom_range(1, q.size());
            while (q.size() > zeros) void'(q.pop_back());
         end
      end
      nbytes = q.size();
      add_frame(q);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_backlog.size() != 0 || req_valid || records_due.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input int byte_target,
                            input bit long_hold);
      int total;
      int n;
      @(negedge clock);
      sender_idle_pct = s_pct;
      recv_stall_pct = r_pct;
      if (long_hold) begin
         hold_on = 1'b1;
         fork
            begin
               repeat (400) @(negedge clock);
               hold_on = 1'b0;
            end
         join_none
      end
      total = 0;
      while (total < byte_target) begin
         add_random_frame(n);
         total += n;
      end
      wait_drained();
   endtask

   initial begin
      byte_queue_type fq;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // key frame; third type byte is the last byte
      fq = {8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h00, 8'h01, 8'h68,
            8'hAA, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
      add_frame(fq);
      fq = {8'hFF};
      add_frame(fq);
      // four zeros before the start mark
      fq = {8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67};
      add_frame(fq);
      // ends on the start mark
      fq = {8'h00, 8'h00, 8'h01};
      add_frame(fq);
      // wrong type in first header
      fq = {8'h00, 8'h00, 8'h01, 8'h68};
      add_frame(fq);
      wait_drained();

      csr_write(REG_BASE_OFFSET, 32'hFFFF_FFF0);
      csr_write(REG_FRAME_LIMIT, 32'h000F_FFFF);
      csr_write(REG_SYNC_LIMIT, 32'h000F_FFFF);
      csr_write(REG_UNUSED, $urandom);
      run_phase(51, 0, 450, 1'b0);

      csr_write(REG_FRAME_LIMIT, 32'd0);
      csr_write(REG_SYNC_LIMIT, 32'd0);
      csr_write(REG_BASE_OFFSET, 32'd0);
      run_phase(0, 51, 400, 1'b0);

      csr_write(REG_FRAME_LIMIT, 32'(ix_size_entries) + 32'd4);
      csr_write(REG_SYNC_LIMIT, 32'd2);
      csr_write(REG_BASE_OFFSET, $urandom);
      run_phase(24, 24, 550, 1'b0);

      csr_write(REG_FRAME_LIMIT, 32'd1);
      csr_write(REG_SYNC_LIMIT, $urandom_range(0, 60));
      csr_write(REG_BASE_OFFSET, 32'hFFFF_FFFF);
      run_phase(0, 0, 350, 1'b1);

      repeat (10) @(posedge clock);
      if (errors == 0 && records_due.size() == 0) begin
         $display("PASS h264_frame_indexer_unit");
      end else begin
         $display("FAIL h264_frame_indexer_unit");
      end
      $finish;
   end

endmodule
